// File: rtl/core/dbcs_pkg.sv
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared constants and item types for the double-byte text filter.
// ----------------------------------------------------------------------------
package dbcs_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned CODE_W  = 16;

	localparam logic [7:0] LEAD_MIN = 8'd160;
	localparam logic [7:0] SPACE    = 8'd32;

	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// one candidate result; cond marks a byte dropped on a table hit
	typedef struct packed {
		logic       v;
		logic       cond;
		logic [7:0] data;
	} slot_t;

	// item travelling down the cell chain
	typedef struct packed {
		logic              valid;
		logic              load;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic              last;
		logic              hit;
		slot_t             s0;
		slot_t             s1;
	} token_t;

endpackage

// File: rtl/core/dbcs_front.sv
// ----------------------------------------------------------------------------
// dbcs_front
// One-byte hold stage: plans the results of each text item and the lookup
// code, and turns load items into table writes for the chain.
// ----------------------------------------------------------------------------
module dbcs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	input  logic                             accept,
	input  logic                             count_zero,
	input  logic                             mode,
	input  logic [7:0]                       text_byte,
	input  logic                             text_end,
	input  logic [dbcs_pkg::IDX_W-1:0]       entry_index,
	input  logic [dbcs_pkg::CODE_W-1:0]      entry_code,
	output dbcs_pkg::token_t                 tok
);

	typedef enum logic [1:0] {KIND_NONE, KIND_LEAD, KIND_SPACE} kind_t;

	kind_t      kind_q, kind_d;
	logic [7:0] held_q, held_d;

	always_comb begin
		tok       = '0;
		tok.valid = valid;
		kind_d    = kind_q;
		held_d    = held_q;
		if (mode == dbcs_pkg::MODE_LOAD) begin
			tok.load = 1'b1;
			tok.idx  = entry_index;
			tok.code = entry_code;
		end else begin
			tok.last = text_end;
			kind_d   = KIND_NONE;
			held_d   = '0;
			if (count_zero) begin
				tok.s0 = '{v: (kind_q != KIND_NONE), cond: 1'b0, data: held_q};
				tok.s1 = '{v: 1'b1, cond: 1'b0, data: text_byte};
			end else if (kind_q == KIND_LEAD) begin
				tok.code = {held_q, text_byte};
				tok.s0   = '{v: 1'b1, cond: 1'b1, data: held_q};
				tok.s1   = '{v: 1'b1, cond: 1'b1, data: text_byte};
			end else begin
				tok.s0 = '{v: (kind_q == KIND_SPACE) && (text_byte != dbcs_pkg::SPACE),
					cond: 1'b0, data: held_q};
				if (text_byte >= dbcs_pkg::LEAD_MIN) begin
					if (text_end) begin
						tok.code = {text_byte, 8'h00};
						tok.s1   = '{v: 1'b1, cond: 1'b1, data: text_byte};
					end else begin
						kind_d = KIND_LEAD;
						held_d = text_byte;
					end
				end else if (text_byte == dbcs_pkg::SPACE && !text_end) begin
					kind_d = KIND_SPACE;
					held_d = text_byte;
				end else begin
					tok.s1 = '{v: 1'b1, cond: 1'b0, data: text_byte};
				end
			end
			if (text_end) begin
				kind_d = KIND_NONE;
				held_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			held_q <= '0;
		end else if (accept) begin
			kind_q <= kind_d;
			held_q <= held_d;
		end
	end

endmodule

// File: rtl/core/dbcs_cell.sv
// ----------------------------------------------------------------------------
// dbcs_cell
// One table slot: takes its write from a passing load item, compares its code
// with text items while enabled by the entry count, and hands each item on.
// ----------------------------------------------------------------------------
module dbcs_cell #(
	parameter int unsigned CELL_ID = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [dbcs_pkg::COUNT_W-1:0]      count,
	input  dbcs_pkg::token_t                  tok_i,
	output dbcs_pkg::token_t                  tok_o
);

	logic [dbcs_pkg::CODE_W-1:0] entry_q;
	logic                        en;
	logic                        wr;
	logic                        hit;
	logic                        valid_q;
	dbcs_pkg::token_t            tok_n;
	dbcs_pkg::token_t            tok_q;

	assign en  = 32'(count) > CELL_ID;
	assign wr  = adv && tok_i.valid && tok_i.load && (32'(tok_i.idx) == CELL_ID);
	assign hit = tok_i.hit || (en && !tok_i.load && (entry_q == tok_i.code));

	always_comb begin
		tok_n     = tok_i;
		tok_n.hit = hit;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= tok_i.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_n;
		end
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = valid_q;
	end

endmodule

// File: rtl/core/dbcs_out.sv
// ----------------------------------------------------------------------------
// dbcs_out
// Resolves the planned results of the item leaving the chain and queues
// up to two of them for the output stream.
// ----------------------------------------------------------------------------
module dbcs_out (
	input  logic             clk,
	input  logic             arst_n,
	input  dbcs_pkg::token_t tail,
	output logic             adv,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	typedef struct packed {
		logic [7:0] data;
		logic       bv;
		logic       eot;
	} res_t;

	logic       k0, k1;
	res_t       r0_d, r1_d;
	logic [1:0] n_d;
	logic [1:0] cnt_q;
	res_t       res0_q, res1_q;
	logic       pop, take;

	assign k0 = tail.s0.v && !(tail.s0.cond && tail.hit);
	assign k1 = tail.s1.v && !(tail.s1.cond && tail.hit);

	always_comb begin
		r0_d = '0;
		r1_d = '0;
		n_d  = 2'd0;
		if (k0) begin
			r0_d = '{data: tail.s0.data, bv: 1'b1, eot: 1'b0};
			n_d  = 2'd1;
			if (k1) begin
				r1_d = '{data: tail.s1.data, bv: 1'b1, eot: 1'b0};
				n_d  = 2'd2;
			end
		end else if (k1) begin
			r0_d = '{data: tail.s1.data, bv: 1'b1, eot: 1'b0};
			n_d  = 2'd1;
		end else if (tail.last) begin
			n_d = 2'd1;
		end
		if (tail.last) begin
			if (n_d == 2'd2) begin
				r1_d.eot = 1'b1;
			end else begin
				r0_d.eot = 1'b1;
			end
		end
	end

	assign pop  = (cnt_q != 2'd0) && m_tready;
	assign take = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign adv  = !tail.valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (tail.valid && take) begin
			cnt_q <= n_d;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid && take) begin
			res0_q <= r0_d;
			res1_q <= r1_d;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = res0_q.data;
	assign m_tuser  = res0_q.bv;
	assign m_tlast  = res0_q.eot;

endmodule

// File: rtl/core/dbcs_char_filter.sv
// ----------------------------------------------------------------------------
// dbcs_char_filter
// Double-byte text filter: drops table-listed lead-byte pairs and doubled
// spaces from a byte stream, with a table loaded through the same stream.
// ----------------------------------------------------------------------------
// An item passes the cell registers and the output queue register before its
// first result; a held lead byte or space leaves with the next text item.
// Throughput: one item per cycle while the output accepts; the cell chain
// carries the table lookup; an item with two results stalls it until one leaves.
// Reset clears the hold stage, entry count and all valid flags; table
// contents stay undefined until loaded.
module dbcs_char_filter #(
	parameter int unsigned TABLE_ENTRIES = dbcs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [dbcs_pkg::COUNT_W-1:0] cfg_wdata,   // entry_count
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,     // text_byte, entry_index, entry_code
	input  logic                         s_tuser,     // mode
	input  logic                         s_tlast,     // text_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,     // out_byte
	output logic                         m_tuser,     // byte_valid
	output logic                         m_tlast      // end_of_text
);

	logic [dbcs_pkg::COUNT_W-1:0] count_q;
	logic                         adv;
	logic                         accept;
	dbcs_pkg::token_t             tok_c [TABLE_ENTRIES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wen) begin
			count_q <= cfg_wdata;
		end
	end

	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	dbcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (s_tvalid),
		.accept     (accept),
		.count_zero (count_q == '0),
		.mode       (s_tuser),
		.text_byte  (s_tdata[7:0]),
		.text_end   (s_tlast),
		.entry_index(s_tdata[13:8]),
		.entry_code (s_tdata[29:14]),
		.tok        (tok_c[0])
	);

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		dbcs_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.count (count_q),
			.tok_i (tok_c[i]),
			.tok_o (tok_c[i+1])
		);
	end

	dbcs_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.tail    (tok_c[TABLE_ENTRIES]),
		.adv     (adv),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// File: rtl/core/dbcs_checker.sv
// ----------------------------------------------------------------------------
// dbcs_checker
// Port-level checks on the filter's output stream.
// ----------------------------------------------------------------------------
module dbcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item withdrawn");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("end-only marker without end flag");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 8'd0)
		else $error("end-only marker carries a byte");

endmodule

bind dbcs_char_filter dbcs_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// File: sim/dbcs_char_filter_tb.sv
// ----------------------------------------------------------------------------
// dbcs_char_filter_tb
// Self-checking bench for the double-byte text filter. The filter table is
// loaded through the input stream and the entry count is stepped through
// zero, one, full and oversized settings. A short directed run covers pair
// drops, doubled spaces and end-of-text cases, then random text follows.
// Random text mixes pairs taken from the live table with single bytes and loads.
// Every output item is checked against an in-bench model of the filter.
// ----------------------------------------------------------------------------
typedef enum logic [1:0] {HOLD_NONE, HOLD_LEAD, HOLD_SPACE} hold_kind_t;

typedef struct packed {
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_text;
} text_out_t;

class filter_tracker;
	logic [15:0] code_table [dbcs_pkg::TABLE_ENTRIES_DEF];
	logic [7:0]  held_byte;
	hold_kind_t  held_kind;
	logic [6:0]  entry_count;
	text_out_t   due_bytes[$];
	int          mismatches;

	function new();
		held_byte   = 8'h00;
		held_kind   = HOLD_NONE;
		entry_count = '0;
		mismatches  = 0;
	endfunction

	function bit pair_listed(logic [7:0] lead, logic [7:0] trail);
		int lim;
		lim = (entry_count > dbcs_pkg::TABLE_ENTRIES_DEF) ?
		      dbcs_pkg::TABLE_ENTRIES_DEF : entry_count;
		for (int k = 0; k < lim; k++)
			if (code_table[k] == {lead, trail})
				return 1'b1;
		return 1'b0;
	endfunction

	function text_out_t kept(logic [7:0] b);
		return text_out_t'{out_byte: b, byte_valid: 1'b1, end_of_text: 1'b0};
	endfunction

	function void note_item(logic mode, logic [7:0] txt, logic at_end,
	                        logic [dbcs_pkg::IDX_W-1:0] idx,
	                        logic [dbcs_pkg::CODE_W-1:0] code);
		text_out_t outs[$];
		bit fresh;
		fresh = 1'b1;
		if (mode == dbcs_pkg::MODE_LOAD) begin
			code_table[idx] = code;
			return;
		end
		if (entry_count == 0) begin
			if (held_kind == HOLD_LEAD || held_kind == HOLD_SPACE)
				outs.push_back(kept(held_byte));
			outs.push_back(kept(txt));
			fresh = 1'b0;
		end else if (held_kind == HOLD_LEAD) begin
			if (!pair_listed(held_byte, txt)) begin
				outs.push_back(kept(held_byte));
				outs.push_back(kept(txt));
			end
			fresh = 1'b0;
		end else if (held_kind == HOLD_SPACE) begin
			if (txt != dbcs_pkg::SPACE)
				outs.push_back(kept(held_byte));
		end
		held_kind = HOLD_NONE;
		held_byte = 8'h00;
		if (fresh) begin
			if (txt >= dbcs_pkg::LEAD_MIN) begin
				if (at_end) begin
					if (!pair_listed(txt, 8'h00))
						outs.push_back(kept(txt));
				end else begin
					held_kind = HOLD_LEAD;
					held_byte = txt;
				end
			end else if (txt == dbcs_pkg::SPACE && !at_end) begin
				held_kind = HOLD_SPACE;
				held_byte = txt;
			end else begin
				outs.push_back(kept(txt));
			end
		end
		if (at_end) begin
			held_kind = HOLD_NONE;
			held_byte = 8'h00;
			if (outs.size() == 0)
				outs.push_back(text_out_t'{out_byte: 8'h00, byte_valid: 1'b0,
				                           end_of_text: 1'b0});
			outs[outs.size()-1].end_of_text = 1'b1;
		end
		foreach (outs[i])
			due_bytes.push_back(outs[i]);
	endfunction

	function void check_output(text_out_t got);
		text_out_t want;
		if (due_bytes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected item: byte %02h valid %0d end %0d",
				         got.out_byte, got.byte_valid, got.end_of_text);
			return;
		end
		want = due_bytes.pop_front();
		if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
		    got.end_of_text !== want.end_of_text) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: expected byte %02h valid %0d end %0d, ",
				          "got byte %02h valid %0d end %0d"},
				         want.out_byte, want.byte_valid, want.end_of_text,
				         got.out_byte, got.byte_valid, got.end_of_text);
		end
	endfunction
endclass

module dbcs_char_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = dbcs_pkg::TABLE_ENTRIES_DEF;
	localparam int LIMIT   = 300000;
	localparam int DRAIN   = 2 * ENTRIES + 16;
	localparam int PHASES  = 9;
	localparam int PHASE_ITEMS = 200;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wen;
	logic [dbcs_pkg::COUNT_W-1:0] cfg_wdata;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [31:0]                  s_tdata;
	logic                         s_tuser;
	logic                         s_tlast;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [7:0]                   m_tdata;
	logic                         m_tuser;
	logic                         m_tlast;

	filter_tracker filt;
	bit calm;
	bit tx_gaps;
	bit rx_gaps;
	bit long_hold_req;
	int cycles;

	dbcs_char_filter #(.TABLE_ENTRIES(ENTRIES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : output_side
		int stall_left;
		text_out_t got;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = text_out_t'{out_byte: m_tdata, byte_valid: m_tuser,
				                  end_of_text: m_tlast};
				filt.check_output(got);
			end
			if (long_hold_req) begin
				stall_left = 300;
				long_hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && rx_gaps && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [15:0] rand_code();
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom_range(0, 65535));
		return {8'($urandom_range(160, 255)), 8'($urandom_range(0, 255))};
	endfunction

	task automatic push_item(logic mode, logic [7:0] txt, logic at_end,
	                         logic [dbcs_pkg::IDX_W-1:0] idx,
	                         logic [dbcs_pkg::CODE_W-1:0] code);
		if (!calm && tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tlast  <= at_end;
		s_tdata  <= {2'b00, code, idx, txt};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		filt.note_item(mode, txt, at_end, idx, code);
	endtask

	task automatic send_text(logic [7:0] txt, logic at_end);
		push_item(dbcs_pkg::MODE_TEXT, txt, at_end,
		          dbcs_pkg::IDX_W'($urandom_range(0, ENTRIES - 1)),
		          16'($urandom_range(0, 65535)));
	endtask

	task automatic send_load(logic [dbcs_pkg::IDX_W-1:0] idx,
	                         logic [dbcs_pkg::CODE_W-1:0] code);
		push_item(dbcs_pkg::MODE_LOAD, 8'($urandom_range(0, 255)),
		          1'($urandom_range(0, 1)), idx, code);
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		while (filt.due_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_count(logic [dbcs_pkg::COUNT_W-1:0] value);
		drain_all();
		// loads and dropped pairs give no item, so let the cell chain empty
		repeat (ENTRIES + 8) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		filt.entry_count = value;
	endtask

	initial begin : stimulus
		logic [dbcs_pkg::COUNT_W-1:0] phase_counts [PHASES];
		logic [15:0] code;
		int n;
		int lim;
		int k;
		int r;

		filt = new();
		calm = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		long_hold_req = 1'b0;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = dbcs_pkg::MODE_TEXT;
		s_tlast   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ENTRIES; i++) begin
			case (i)
				0:       code = 16'hA0A1;
				1:       code = 16'hFFFF;
				2:       code = 16'hB000;
				3:       code = 16'hA0A0;
				63:      code = 16'h0000;
				default: code = rand_code();
			endcase
			send_load(dbcs_pkg::IDX_W'(i), code);
		end

		set_count(7'd4);
		send_text(8'hA0, 1'b0); send_text(8'hA1, 1'b0);
		send_text(8'hA0, 1'b0); send_text(8'hA2, 1'b0);
		send_text(dbcs_pkg::SPACE, 1'b0); send_text(dbcs_pkg::SPACE, 1'b0);
		send_text(8'h41, 1'b0);
		send_text(dbcs_pkg::SPACE, 1'b0); send_text(8'h41, 1'b0);
		send_text(8'hFF, 1'b0); send_text(8'hFF, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'h9F, 1'b0);
		send_text(8'hB0, 1'b1);
		send_text(dbcs_pkg::SPACE, 1'b1);
		send_text(8'hA0, 1'b1);
		push_item(dbcs_pkg::MODE_LOAD, 8'h00, 1'b1, 6'd4, rand_code());
		send_text(8'hA0, 1'b0); send_text(8'hA0, 1'b0);
		send_text(8'hFF, 1'b0); send_text(dbcs_pkg::SPACE, 1'b0);
		send_text(dbcs_pkg::SPACE, 1'b1);
		// lead byte left held across the switch to pass-through
		send_text(8'hA1, 1'b0);

		phase_counts[0] = 7'd0;
		phase_counts[1] = 7'd64;
		phase_counts[2] = 7'd1;
		phase_counts[3] = 7'd127;
		phase_counts[4] = 7'd0;
		phase_counts[5] = 7'd65;
		phase_counts[6] = 7'($urandom_range(2, 63));
		phase_counts[7] = 7'd32;
		phase_counts[8] = 7'($urandom_range(1, 64));

		for (int p = 0; p < PHASES; p++) begin
			set_count(phase_counts[p]);
			tx_gaps = (p % 3 != 2);
			rx_gaps = (p % 4 != 3);
			calm    = (p == PHASES - 1);
			lim = (filt.entry_count > ENTRIES) ? ENTRIES : filt.entry_count;
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (p == 2 && n == 50)
					long_hold_req = 1'b1;
				if (p == 3 && n == 100)
					drain_all();
				r = $urandom_range(0, 99);
				if (r < 6) begin
					send_load(dbcs_pkg::IDX_W'($urandom_range(0, ENTRIES - 1)),
					          rand_code());
					n++;
				end else if (r < 35 && lim > 0) begin
					k = $urandom_range(0, lim - 1);
					code = filt.code_table[k];
					send_text(code[15:8], 1'b0);
					send_text(code[7:0], 1'($urandom_range(0, 7) == 0));
					n += 2;
				end else begin
					if (r < 50)
						code[7:0] = 8'($urandom_range(160, 255));
					else if (r < 68)
						code[7:0] = dbcs_pkg::SPACE;
					else
						code[7:0] = 8'($urandom_range(0, 255));
					send_text(code[7:0], 1'($urandom_range(0, 11) == 0));
					n++;
				end
			end
			// leave a byte held for the next count setting
			if (p % 2 == 0)
				send_text(dbcs_pkg::SPACE, 1'b0);
			else
				send_text(8'($urandom_range(160, 255)), 1'b0);
		end

		drain_all();
		repeat (DRAIN) @(posedge clk);
		if (filt.mismatches == 0 && filt.due_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/dbcs_pkg.sv
rtl/core/dbcs_front.sv
rtl/core/dbcs_cell.sv
rtl/core/dbcs_out.sv
rtl/core/dbcs_char_filter.sv
rtl/core/dbcs_checker.sv
sim/dbcs_char_filter_tb.sv
